[rtl/gasa_pkg.sv]
// Shared types and constants for the glyph atlas shelf allocator.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package gasa_pkg;

	// Default sizes of the atlas.
	localparam int DEF_MIN_SIDE        = 256;
	localparam int DEF_MAX_SIDE        = 2048;
	localparam int DEF_HEIGHT_ROUNDING = 4;
	localparam int DEF_BAND_SLOTS      = 64;
	localparam int DEF_TEXTURE_SLOTS   = 8;

	// Internal value width: holds twice the largest texture side and any band height.
	localparam int VAL_W = 15;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAND_FULL = 2'd1,
		ST_TEX_FULL  = 2'd2,
		ST_TOO_LARGE = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ROUND,
		S_ROUND_FIN,
		S_BSCAN,
		S_TSCAN,
		S_GROW,
		S_OPEN,
		S_CUT_TOP,
		S_CUT_FREE,
		S_TAKE,
		S_FINISH
	} state_t;

endpackage

`default_nettype wire

[rtl/gasa_sub_unit.sv]
// Shared subtract and compare unit of the allocator datapath.
// Uses gasa_pkg for nothing but house consistency of widths handed in.
`timescale 1ns / 1ps
`default_nettype none

module gasa_sub_unit
	import gasa_pkg::*;
#(
	parameter int W = VAL_W
) (
	input  wire logic [W-1:0] a,
	input  wire logic [W-1:0] b,
	output logic      [W-1:0] diff,
	output logic              ge
);

	logic [W:0] wide;

	// Borrow out of the top bit means a < b.
	assign wide = {1'b0, a} - {1'b0, b};
	assign diff = wide[W-1:0];
	assign ge   = ~wide[W];

endmodule

`default_nettype wire

[rtl/gasa_ram.sv]
// Single write port, single registered read port memory.
// Holds the band and texture tables; depends on gasa_pkg only for style.
`timescale 1ns / 1ps
`default_nettype none

module gasa_ram
	import gasa_pkg::*;
#(
	parameter int DEPTH = DEF_BAND_SLOTS,
	parameter int AW    = 6,
	parameter int DW    = VAL_W
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[rtl/glyph_atlas_shelf_allocator.sv]
// Top level of the glyph atlas shelf allocator: sequencer, datapath registers,
// band and texture memories. Depends on gasa_pkg, gasa_sub_unit and gasa_ram.
//
// Channel  | Direction | Handshake             | Beat contents
// ---------+-----------+-----------------------+------------------------------------------
// command  | in        | start high, busy low  | operation, glyph_width/height, offsets
// result   | out       | done high, one cycle  | status, texture, edge, slot, echo fields
//
// Steps: a clear beat goes from acceptance straight to the finish step. An allocate
// beat rounds the band height (round, round finish), then scans the bands, newest
// first, one band memory read a cycle; a band hit then takes the slot and finishes.
// Otherwise the textures are scanned the same way, and when no texture fits the new
// side is grown by doublings and an open step runs; a new band is then cut, the slot
// taken and the beat finished. A failure finishes right after its check. The result
// strobe is registered from the finish step and is high in the cycle after it.
// The single band memory read port sets the scan rate.
// Reset clears the counts and the sequencer; the tables need no clearing pass,
// since only entries below the counts are ever read.
// The receiver cannot stall: the done strobe of each result is high for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module glyph_atlas_shelf_allocator
	import gasa_pkg::*;
#(
	parameter int MIN_SIDE        = DEF_MIN_SIDE,
	parameter int MAX_SIDE        = DEF_MAX_SIDE,
	parameter int HEIGHT_ROUNDING = DEF_HEIGHT_ROUNDING,
	parameter int BAND_SLOTS      = DEF_BAND_SLOTS,
	parameter int TEXTURE_SLOTS   = DEF_TEXTURE_SLOTS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               operation,
	input  wire logic        [10:0] glyph_width,
	input  wire logic        [10:0] glyph_height,
	input  wire logic signed [15:0] draw_offset_x,
	input  wire logic signed [15:0] draw_offset_y,
	output logic                    done,
	output logic             [1:0]  status,
	output logic             [2:0]  texture_index,
	output logic             [11:0] texture_edge,
	output logic             [10:0] slot_x,
	output logic             [10:0] slot_y,
	output logic             [10:0] echo_width,
	output logic             [10:0] echo_height,
	output logic                    opened_texture,
	output logic signed      [15:0] out_offset_x,
	output logic signed      [15:0] out_offset_y
);

	localparam int BIDX_W = $clog2(BAND_SLOTS);
	localparam int BCNT_W = $clog2(BAND_SLOTS + 1);
	localparam int TIDX_W = (TEXTURE_SLOTS > 1) ? $clog2(TEXTURE_SLOTS) : 1;
	localparam int TCNT_W = $clog2(TEXTURE_SLOTS + 1);
	// Band entry: top row, rounded height, free width, texture index.
	localparam int BE_W   = 3 * VAL_W + TIDX_W;
	// Texture entry: side, free height.
	localparam int TE_W   = 2 * VAL_W;

	// Rounding by reciprocal multiplication: the rounded-up sum is below 2^RND_N,
	// so a multiplier of RND_N + 1 bits and a shift give the exact quotient.
	localparam int RND_N  = 12;
	localparam int RND_MW = RND_N + 1;
	localparam int RND_L  = $clog2(HEIGHT_ROUNDING);
	localparam int RND_S  = RND_N + RND_L;
	localparam int RND_M  = ((1 << RND_S) + HEIGHT_ROUNDING - 1) / HEIGHT_ROUNDING;

	localparam logic [VAL_W-1:0]  MIN_SIDE_V = VAL_W'(MIN_SIDE);
	localparam logic [VAL_W-1:0]  MAX_SIDE_V = VAL_W'(MAX_SIDE);
	localparam logic [VAL_W-1:0]  ROUND_V    = VAL_W'(HEIGHT_ROUNDING);
	localparam logic [RND_MW-1:0] RND_MV     = RND_MW'(RND_M);
	localparam logic [BCNT_W-1:0] BAND_LIM   = BCNT_W'(BAND_SLOTS);
	localparam logic [TCNT_W-1:0] TEX_LIM    = TCNT_W'(TEXTURE_SLOTS);

	// Sequencer and control state.
	state_t              state_q, state_d;
	logic [BCNT_W-1:0]   band_count_q;
	logic [TCNT_W-1:0]   tex_count_q;
	logic [BCNT_W-1:0]   b_cnt_q;
	logic [TCNT_W-1:0]   t_cnt_q;
	logic                bchk_v_s1;
	logic                tchk_v_s1;
	logic                done_q;

	// Item payload and working registers.
	logic                clr_q;
	logic [10:0]         gw_q, gh_q;
	logic [15:0]         ox_q, oy_q;
	logic [VAL_W-1:0]    pw_q, bh_q;
	logic [RND_N-1:0]    num_q, quo_q;
	logic [VAL_W-1:0]    side_q, tfree_q, top_q, bfree_q;
	logic [BIDX_W-1:0]   slot_q;
	logic [TIDX_W-1:0]   btex_q;
	logic [BIDX_W-1:0]   bchk_addr_s1;
	logic [TIDX_W-1:0]   tchk_addr_s1;
	status_t             status_q;
	logic                opened_q;

	// Result register.
	status_t             o_status_q;
	logic [2:0]          o_tex_q;
	logic [11:0]         o_edge_q;
	logic [10:0]         o_x_q, o_y_q, o_w_q, o_h_q;
	logic                o_open_q;
	logic [15:0]         o_ox_q, o_oy_q;

	// Shared unit and memory ports.
	logic [VAL_W-1:0]    su_a, su_b, su_diff;
	logic                su_ge;
	logic                b_we, t_we;
	logic [BIDX_W-1:0]   b_raddr;
	logic [TIDX_W-1:0]   t_raddr;
	logic [BE_W-1:0]     b_wdata, b_rdata;
	logic [TE_W-1:0]     t_wdata, t_rdata;

	logic [BCNT_W-1:0]   b_cnt_dec;
	logic [TCNT_W-1:0]   t_cnt_dec;
	logic [VAL_W-1:0]    b_rd_top, b_rd_height, b_rd_free;
	logic [TIDX_W-1:0]   b_rd_tex;
	logic [VAL_W-1:0]    t_rd_side, t_rd_free;
	logic                b_hit, t_hit, b_scan_end, t_scan_end;
	logic                band_full, grow_more, open_ok;
	logic [TIDX_W+2:0]   tex_ext;
	logic [RND_N+RND_MW-1:0] rnd_prod;
	logic [RND_N-1:0]    rnd_quo;

	gasa_sub_unit #(.W(VAL_W)) u_sub (
		.a    (su_a),
		.b    (su_b),
		.diff (su_diff),
		.ge   (su_ge)
	);

	gasa_ram #(.DEPTH(BAND_SLOTS), .AW(BIDX_W), .DW(BE_W)) u_band_ram (
		.clk   (clk),
		.we    (b_we),
		.waddr (slot_q),
		.wdata (b_wdata),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	gasa_ram #(.DEPTH(TEXTURE_SLOTS), .AW(TIDX_W), .DW(TE_W)) u_tex_ram (
		.clk   (clk),
		.we    (t_we),
		.waddr (btex_q),
		.wdata (t_wdata),
		.raddr (t_raddr),
		.rdata (t_rdata)
	);

	// Unpack the registered read data.
	assign {b_rd_top, b_rd_height, b_rd_free, b_rd_tex} = b_rdata;
	assign {t_rd_side, t_rd_free}                       = t_rdata;

	assign b_cnt_dec = b_cnt_q - 1'b1;
	assign t_cnt_dec = t_cnt_q - 1'b1;

	// Quotient of the padded height plus rounding minus one by the rounding.
	assign rnd_prod = {{RND_MW{1'b0}}, num_q} * {{RND_N{1'b0}}, RND_MV};
	assign rnd_quo  = RND_N'(rnd_prod >> RND_S);

	// A band fits when its height matches and the shared unit finds free >= padded width.
	assign b_hit      = bchk_v_s1 && (b_rd_height == bh_q) && su_ge;
	assign b_scan_end = (b_cnt_q == '0) && !bchk_v_s1;
	// A texture fits when free height >= band height (shared unit) and side >= padded width.
	assign t_hit      = tchk_v_s1 && su_ge && (t_rd_side >= pw_q);
	assign t_scan_end = (t_cnt_q == '0) && !tchk_v_s1;

	assign band_full = band_count_q >= BAND_LIM;
	assign grow_more = ((side_q < bh_q) || (side_q < pw_q)) && (side_q <= MAX_SIDE_V);
	assign open_ok   = (side_q <= MAX_SIDE_V) && (tex_count_q < TEX_LIM);
	assign tex_ext   = {3'b000, btex_q};

	assign b_wdata = {top_q, bh_q, su_diff, btex_q};
	assign t_wdata = {side_q, su_diff};

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = operation ? S_FINISH : S_ROUND;
				end
			end
			S_ROUND:     state_d = S_ROUND_FIN;
			S_ROUND_FIN: state_d = S_BSCAN;
			S_BSCAN: begin
				if (b_hit) begin
					state_d = S_TAKE;
				end else if (b_scan_end) begin
					state_d = band_full ? S_FINISH : S_TSCAN;
				end
			end
			S_TSCAN: begin
				if (t_hit) begin
					state_d = S_CUT_TOP;
				end else if (t_scan_end) begin
					state_d = S_GROW;
				end
			end
			S_GROW: begin
				if (!grow_more) begin
					state_d = S_OPEN;
				end
			end
			S_OPEN:     state_d = open_ok ? S_CUT_TOP : S_FINISH;
			S_CUT_TOP:  state_d = S_CUT_FREE;
			S_CUT_FREE: state_d = S_TAKE;
			S_TAKE:     state_d = S_FINISH;
			S_FINISH:   state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	// Shared unit operands, memory addresses and write enables.
	always_comb begin
		su_a    = '0;
		su_b    = '0;
		b_we    = 1'b0;
		t_we    = 1'b0;
		b_raddr = b_cnt_dec[BIDX_W-1:0];
		t_raddr = t_cnt_dec[TIDX_W-1:0];
		busy    = (state_q != S_IDLE);
		case (state_q)
			S_BSCAN: begin
				su_a = b_rd_free;
				su_b = pw_q;
			end
			S_TSCAN: begin
				su_a = t_rd_free;
				su_b = bh_q;
			end
			S_CUT_TOP: begin
				su_a = side_q;
				su_b = tfree_q;
			end
			S_CUT_FREE: begin
				su_a = tfree_q;
				su_b = bh_q;
				t_we = 1'b1;
			end
			S_TAKE: begin
				su_a    = bfree_q;
				su_b    = pw_q;
				b_we    = 1'b1;
				t_raddr = btex_q;
			end
			default: begin
				su_a = '0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			band_count_q <= '0;
			tex_count_q  <= '0;
			b_cnt_q      <= '0;
			t_cnt_q      <= '0;
			bchk_v_s1    <= 1'b0;
			tchk_v_s1    <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_FINISH);
			case (state_q)
				S_IDLE: begin
					// Clear drops every band and texture at once.
					if (start && operation) begin
						band_count_q <= '0;
						tex_count_q  <= '0;
					end
				end
				S_ROUND_FIN: begin
					b_cnt_q   <= band_count_q;
					bchk_v_s1 <= 1'b0;
				end
				S_BSCAN: begin
					// Issue the next older band while checking the one read last cycle.
					if (b_cnt_q != '0) begin
						b_cnt_q   <= b_cnt_dec;
						bchk_v_s1 <= 1'b1;
					end else begin
						bchk_v_s1 <= 1'b0;
					end
					if (!b_hit && b_scan_end) begin
						t_cnt_q   <= tex_count_q;
						tchk_v_s1 <= 1'b0;
					end
				end
				S_TSCAN: begin
					if (t_cnt_q != '0) begin
						t_cnt_q   <= t_cnt_dec;
						tchk_v_s1 <= 1'b1;
					end else begin
						tchk_v_s1 <= 1'b0;
					end
				end
				S_OPEN: begin
					if (open_ok) begin
						tex_count_q <= tex_count_q + 1'b1;
					end
				end
				S_CUT_FREE: begin
					band_count_q <= band_count_q + 1'b1;
				end
				default: begin
					b_cnt_q <= b_cnt_q;
				end
			endcase
		end
	end

	// Working registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					clr_q    <= operation;
					gw_q     <= glyph_width;
					gh_q     <= glyph_height;
					ox_q     <= draw_offset_x;
					oy_q     <= draw_offset_y;
					pw_q     <= VAL_W'(glyph_width) + 1'b1;
					// Padded height plus rounding minus one.
					num_q    <= RND_N'(glyph_height) + RND_N'(HEIGHT_ROUNDING);
					status_q <= ST_OK;
					opened_q <= 1'b0;
				end
			end
			S_ROUND: begin
				quo_q <= rnd_quo;
			end
			S_ROUND_FIN: begin
				bh_q <= VAL_W'(quo_q) * ROUND_V;
			end
			S_BSCAN: begin
				if (b_cnt_q != '0) begin
					bchk_addr_s1 <= b_cnt_dec[BIDX_W-1:0];
				end
				if (b_hit) begin
					slot_q  <= bchk_addr_s1;
					top_q   <= b_rd_top;
					bfree_q <= b_rd_free;
					btex_q  <= b_rd_tex;
				end else if (b_scan_end && band_full) begin
					status_q <= ST_BAND_FULL;
				end
			end
			S_TSCAN: begin
				if (t_cnt_q != '0) begin
					tchk_addr_s1 <= t_cnt_dec[TIDX_W-1:0];
				end
				if (t_hit) begin
					btex_q  <= tchk_addr_s1;
					side_q  <= t_rd_side;
					tfree_q <= t_rd_free;
				end else if (t_scan_end) begin
					side_q <= MIN_SIDE_V;
				end
			end
			S_GROW: begin
				if (grow_more) begin
					side_q <= {side_q[VAL_W-2:0], 1'b0};
				end
			end
			S_OPEN: begin
				if (side_q > MAX_SIDE_V) begin
					status_q <= ST_TOO_LARGE;
				end else if (!open_ok) begin
					status_q <= ST_TEX_FULL;
				end else begin
					btex_q   <= tex_count_q[TIDX_W-1:0];
					tfree_q  <= side_q;
					opened_q <= 1'b1;
				end
			end
			S_CUT_TOP: begin
				// New band starts where the texture's free space begins.
				top_q   <= su_diff;
				bfree_q <= side_q;
			end
			S_CUT_FREE: begin
				slot_q <= band_count_q[BIDX_W-1:0];
			end
			S_TAKE: begin
				// Slot is handed out from the right end of the band.
				bfree_q <= su_diff;
			end
			default: begin
				clr_q <= clr_q;
			end
		endcase
	end

	// Result register, loaded in the last sequencer step.
	always_ff @(posedge clk) begin
		if (state_q == S_FINISH) begin
			if (clr_q) begin
				o_status_q <= ST_OK;
				o_tex_q    <= '0;
				o_edge_q   <= '0;
				o_x_q      <= '0;
				o_y_q      <= '0;
				o_w_q      <= '0;
				o_h_q      <= '0;
				o_open_q   <= 1'b0;
				o_ox_q     <= '0;
				o_oy_q     <= '0;
			end else begin
				o_status_q <= status_q;
				o_w_q      <= gw_q;
				o_h_q      <= gh_q;
				o_ox_q     <= ox_q;
				o_oy_q     <= oy_q;
				if (status_q == ST_OK) begin
					o_tex_q  <= tex_ext[2:0];
					o_edge_q <= t_rd_side[11:0];
					o_x_q    <= bfree_q[10:0];
					o_y_q    <= top_q[10:0];
					o_open_q <= opened_q;
				end else begin
					o_tex_q  <= '0;
					o_edge_q <= '0;
					o_x_q    <= '0;
					o_y_q    <= '0;
					o_open_q <= 1'b0;
				end
			end
		end
	end

	assign done           = done_q;
	assign status         = o_status_q;
	assign texture_index  = o_tex_q;
	assign texture_edge   = o_edge_q;
	assign slot_x         = o_x_q;
	assign slot_y         = o_y_q;
	assign echo_width     = o_w_q;
	assign echo_height    = o_h_q;
	assign opened_texture = o_open_q;
	assign out_offset_x   = o_ox_q;
	assign out_offset_y   = o_oy_q;

endmodule

`default_nettype wire

[rtl/gasa_checker.sv]
// Port-level checks of the glyph atlas shelf allocator, bound to the top level.
// Depends on gasa_pkg for the status codes.
`timescale 1ns / 1ps
`default_nettype none

module gasa_checker
	import gasa_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic [1:0]  status,
	input wire logic [2:0]  texture_index,
	input wire logic [11:0] texture_edge,
	input wire logic [10:0] slot_x,
	input wire logic [10:0] slot_y,
	input wire logic        opened_texture
);

	// Accepted beat holds the block busy.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted beat did not raise busy");

	// A result only shows once the block has gone idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// One result per beat, never two in a row.
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	// Failed allocation carries no placement.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != ST_OK) |-> (texture_index == '0) && (texture_edge == '0)
			&& (slot_x == '0) && (slot_y == '0) && !opened_texture)
		else $error("failed allocation shows a placement");

	// Opening a texture implies success and a nonzero edge.
	a_open_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && opened_texture |-> (status == ST_OK) && (texture_edge != '0))
		else $error("texture opened on a failed allocation");

endmodule

bind glyph_atlas_shelf_allocator gasa_checker u_gasa_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.done           (done),
	.status         (status),
	.texture_index  (texture_index),
	.texture_edge   (texture_edge),
	.slot_x         (slot_x),
	.slot_y         (slot_y),
	.opened_texture (opened_texture)
);

`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking bench for glyph_atlas_shelf_allocator: random and directed glyph
// commands, an in-bench shelf packing predictor and a result scoreboard.
// Depends on gasa_pkg and the RTL of the block.
`timescale 1ns / 1ps

module testbench;
	import gasa_pkg::*;

	// Atlas sizes, matching the defaults the block is built with.
	localparam int MIN_SIDE       = DEF_MIN_SIDE;
	localparam int MAX_SIDE       = DEF_MAX_SIDE;
	localparam int ROUNDING       = DEF_HEIGHT_ROUNDING;
	localparam int BAND_SLOTS     = DEF_BAND_SLOTS;
	localparam int TEXTURE_SLOTS  = DEF_TEXTURE_SLOTS;

	// The watchdog limit lies well above the longest allocate beat and sender gap.
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 120;
	localparam int TARGET_CMDS    = 1400;

	typedef enum bit {
		OP_ALLOC = 1'b0,
		OP_CLEAR = 1'b1
	} op_t;

	typedef struct packed {
		op_t                op;
		logic        [10:0] width;
		logic        [10:0] height;
		logic signed [15:0] off_x;
		logic signed [15:0] off_y;
	} glyph_cmd_t;

	typedef struct packed {
		status_t            status;
		logic        [2:0]  tex;
		logic        [11:0] tex_side;
		logic        [10:0] x;
		logic        [10:0] y;
		logic        [10:0] width;
		logic        [10:0] height;
		logic               opened;
		logic signed [15:0] off_x;
		logic signed [15:0] off_y;
	} slot_rec_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               operation = 1'b0;
	logic        [10:0] glyph_width = '0;
	logic        [10:0] glyph_height = '0;
	logic signed [15:0] draw_offset_x = '0;
	logic signed [15:0] draw_offset_y = '0;
	logic               busy;
	logic               done;
	logic        [1:0]  status;
	logic        [2:0]  texture_index;
	logic        [11:0] texture_edge;
	logic        [10:0] slot_x;
	logic        [10:0] slot_y;
	logic        [10:0] echo_width;
	logic        [10:0] echo_height;
	logic               opened_texture;
	logic signed [15:0] out_offset_x;
	logic signed [15:0] out_offset_y;

	glyph_atlas_shelf_allocator uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.operation      (operation),
		.glyph_width    (glyph_width),
		.glyph_height   (glyph_height),
		.draw_offset_x  (draw_offset_x),
		.draw_offset_y  (draw_offset_y),
		.done           (done),
		.status         (status),
		.texture_index  (texture_index),
		.texture_edge   (texture_edge),
		.slot_x         (slot_x),
		.slot_y         (slot_y),
		.echo_width     (echo_width),
		.echo_height    (echo_height),
		.opened_texture (opened_texture),
		.out_offset_x   (out_offset_x),
		.out_offset_y   (out_offset_y)
	);

	// Commands waiting to be driven, and slot results the block still owes us.
	glyph_cmd_t pending_cmds[$];
	slot_rec_t  slots_due[$];
	glyph_cmd_t cur_cmd;

	int total_cmds = 0;
	int accepted_cmds = 0;
	int failures = 0;
	int idle_cycles = 0;
	int hold_off = 0;
	int calm_left = 0;
	bit beat_taken = 1'b0;

	// Shadow copy of the atlas: the band (shelf) table and the texture (page) table.
	int shelf_count = 0;
	int shelf_row[BAND_SLOTS];
	int shelf_height[BAND_SLOTS];
	int shelf_free[BAND_SLOTS];
	int shelf_tex[BAND_SLOTS];
	int page_count = 0;
	int page_side[TEXTURE_SLOTS];
	int page_free[TEXTURE_SLOTS];

	initial begin
		forever #6 clk = ~clk;
	end

	// Work out the slot one command lands in and advance the shadow atlas.
	task automatic place_glyph(input glyph_cmd_t c, output slot_rec_t r);
		int  pw;
		int  ph;
		int  bh;
		int  side;
		int  tex;
		int  shelf;
		bit  found;
		bit  have_page;
		r = '0;
		tex = 0;
		shelf = 0;
		// A clear drops both tables and answers with an all-zero beat.
		if (c.op == OP_CLEAR) begin
			shelf_count = 0;
			page_count = 0;
			return;
		end
		pw = int'(c.width) + 1;
		ph = int'(c.height) + 1;
		bh = (ph + ROUNDING - 1) / ROUNDING * ROUNDING;
		// Newest band of the same height with room to spare wins.
		found = 1'b0;
		for (int i = shelf_count - 1; i >= 0 && !found; i--) begin
			if (shelf_height[i] == bh && shelf_free[i] >= pw) begin
				shelf = i;
				found = 1'b1;
			end
		end
		r.status = ST_OK;
		if (!found) begin
			if (shelf_count >= BAND_SLOTS) begin
				r.status = ST_BAND_FULL;
			end else begin
				// Otherwise cut a band from the newest texture that can hold it.
				have_page = 1'b0;
				for (int t = page_count - 1; t >= 0 && !have_page; t--) begin
					if (page_free[t] >= bh && page_side[t] >= pw) begin
						tex = t;
						have_page = 1'b1;
					end
				end
				// Otherwise open a texture, doubling the side until the glyph fits.
				if (!have_page) begin
					side = MIN_SIDE;
					while ((side < bh || side < pw) && side <= MAX_SIDE)
						side = side * 2;
					if (side > MAX_SIDE) begin
						r.status = ST_TOO_LARGE;
					end else if (page_count >= TEXTURE_SLOTS) begin
						r.status = ST_TEX_FULL;
					end else begin
						tex = page_count;
						page_side[tex] = side;
						page_free[tex] = side;
						page_count++;
						r.opened = 1'b1;
						have_page = 1'b1;
					end
				end
				if (have_page) begin
					shelf = shelf_count;
					shelf_row[shelf] = page_side[tex] - page_free[tex];
					shelf_height[shelf] = bh;
					shelf_free[shelf] = page_side[tex];
					shelf_tex[shelf] = tex;
					page_free[tex] -= bh;
					shelf_count++;
					found = 1'b1;
				end
			end
		end
		r.width = c.width;
		r.height = c.height;
		r.off_x = c.off_x;
		r.off_y = c.off_y;
		// Space in a band goes right to left: the slot starts at the new free edge.
		if (found) begin
			shelf_free[shelf] -= pw;
			r.tex = 3'(shelf_tex[shelf]);
			r.tex_side = 12'(page_side[shelf_tex[shelf]]);
			r.x = 11'(shelf_free[shelf]);
			r.y = 11'(shelf_row[shelf]);
		end
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endtask

	task automatic queue_cmd(input op_t op, input int w, input int h);
		glyph_cmd_t c;
		c.op = op;
		c.width = 11'(w);
		c.height = 11'(h);
		c.off_x = 16'($urandom());
		c.off_y = 16'($urandom());
		pending_cmds.push_back(c);
	endtask

	// Note each beat the block takes; the prediction runs at the next falling edge,
	// so a result sampled at the same rising edge always meets the older expectation.
	always @(posedge clk) begin
		beat_taken <= arst_n && start && !busy;
	end

	// Driver: predict each taken beat, then either hold the current command, idle,
	// or present the next one. start gets at most one assignment per falling edge.
	always @(negedge clk) begin
		slot_rec_t r;
		int        pick;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (beat_taken) begin
				place_glyph(cur_cmd, r);
				slots_due.push_back(r);
				accepted_cmds++;
				// Choose the gap before the next beat: mostly none or short,
				// now and then long, with calm stretches that run back to back.
				if (calm_left > 0) begin
					calm_left--;
					hold_off = 0;
				end else begin
					pick = $urandom_range(99);
					if (pick < 4)
						calm_left = $urandom_range(10, 40);
					if (pick < 40)
						hold_off = 0;
					else if (pick < 85)
						hold_off = $urandom_range(1, 4);
					else if (pick < 97)
						hold_off = $urandom_range(5, 120);
					else
						hold_off = $urandom_range(121, 200);
				end
			end
			if (start && !beat_taken) begin
				// Hold the command stable until the block takes it.
			end else if (hold_off > 0) begin
				hold_off--;
				start <= 1'b0;
			end else if (pending_cmds.size() > 0) begin
				cur_cmd = pending_cmds.pop_front();
				operation <= cur_cmd.op;
				glyph_width <= cur_cmd.width;
				glyph_height <= cur_cmd.height;
				draw_offset_x <= cur_cmd.off_x;
				draw_offset_y <= cur_cmd.off_y;
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: every done strobe must match the oldest outstanding slot, field by field.
	always @(posedge clk) begin
		slot_rec_t want;
		if (arst_n && done) begin
			if (slots_due.size() == 0) begin
				$error("result beat with no command outstanding");
				failures++;
			end else begin
				want = slots_due.pop_front();
				check_field("status", want.status, status);
				check_field("texture_index", want.tex, texture_index);
				check_field("texture_edge", want.tex_side, texture_edge);
				check_field("slot_x", want.x, slot_x);
				check_field("slot_y", want.y, slot_y);
				check_field("echo_width", want.width, echo_width);
				check_field("echo_height", want.height, echo_height);
				check_field("opened_texture", want.opened, opened_texture);
				check_field("out_offset_x", want.off_x, out_offset_x);
				check_field("out_offset_y", want.off_y, out_offset_y);
			end
		end
	end

	// Watchdog: a run of cycles with neither a command nor a result taken means a hang.
	always @(posedge clk) begin
		if (arst_n && ((start && !busy) || done))
			idle_cycles <= 0;
		else if (arst_n)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL glyph_atlas_shelf_allocator");
			$finish;
		end
	end

	initial begin
		int kind;
		int n;
		int w;
		int h;

		// Directed opening: padding and rounding edges, offset extremes, band reuse,
		// texture growth, a full texture table and clears.
		queue_cmd(OP_CLEAR, $urandom_range(2047), $urandom_range(2047));
		pending_cmds[0].off_x = 16'sh8000;
		pending_cmds[0].off_y = 16'sh7fff;
		queue_cmd(OP_ALLOC, 0, 0);
		pending_cmds[1].off_x = 16'sh8000;
		pending_cmds[1].off_y = 16'sh7fff;
		queue_cmd(OP_ALLOC, 0, 0);
		pending_cmds[2].off_x = 16'sh7fff;
		pending_cmds[2].off_y = 16'sh8000;
		queue_cmd(OP_ALLOC, 5, 3);       // padded height already a multiple of four
		queue_cmd(OP_ALLOC, 5, 4);       // padded height rounds up to the next band
		queue_cmd(OP_ALLOC, 2047, 0);    // widest glyph forces the largest texture
		queue_cmd(OP_ALLOC, 0, 2047);    // tallest glyph takes a whole texture
		queue_cmd(OP_ALLOC, 2047, 2047);
		queue_cmd(OP_ALLOC, 300, 300);   // new band cut from a partly used texture
		queue_cmd(OP_ALLOC, 254, 10);    // new band cut from the same partly used large texture
		for (int i = 0; i < 5; i++)
			queue_cmd(OP_ALLOC, 2047, 2047);   // last of these finds the table full
		queue_cmd(OP_ALLOC, 0, 0);       // still fits in an old band
		queue_cmd(OP_ALLOC, 1000, 1000); // no band fits: new band cut from a partly used texture
		queue_cmd(OP_CLEAR, 2047, 2047);
		queue_cmd(OP_ALLOC, 10, 10);     // tables start over at texture zero
		queue_cmd(OP_ALLOC, 1023, 511);
		queue_cmd(OP_CLEAR, 0, 0);

		// Random part: sessions of allocations that build up an atlas, each closed
		// by a clear, with some fully random noise mixed in.
		while (pending_cmds.size() < TARGET_CMDS) begin
			kind = $urandom_range(99);
			if (kind < 45) begin
				// Typical text: small glyphs, a few large ones.
				n = $urandom_range(20, 70);
				for (int i = 0; i < n; i++) begin
					if ($urandom_range(99) < 88) begin
						w = $urandom_range(0, 40);
						h = $urandom_range(0, 30);
					end else if ($urandom_range(9) != 0) begin
						w = $urandom_range(0, 400);
						h = $urandom_range(0, 300);
					end else begin
						w = $urandom_range(2047);
						h = $urandom_range(2047);
					end
					queue_cmd(OP_ALLOC, w, h);
				end
			end else if (kind < 65) begin
				// One wide glyph per band: runs the band table to full.
				n = $urandom_range(66, 80);
				for (int i = 0; i < n; i++)
					queue_cmd(OP_ALLOC, $urandom_range(140, 254), $urandom_range(0, 14));
			end else if (kind < 80) begin
				// Tall glyphs: opens textures until the table is full.
				n = $urandom_range(10, 30);
				for (int i = 0; i < n; i++)
					queue_cmd(OP_ALLOC, $urandom_range(2047), $urandom_range(100, 2047));
			end else if (kind < 95) begin
				// Noise: any field value, stray clears included.
				n = $urandom_range(10, 40);
				for (int i = 0; i < n; i++)
					queue_cmd(($urandom_range(9) == 0) ? OP_CLEAR : OP_ALLOC,
						$urandom_range(2047), $urandom_range(2047));
			end else begin
				// One size over and over: packs bands right to left, then spills over.
				n = $urandom_range(30, 60);
				w = $urandom_range(0, 100);
				h = $urandom_range(0, 60);
				for (int i = 0; i < n; i++)
					queue_cmd(OP_ALLOC, w, h);
			end
			queue_cmd(OP_CLEAR, $urandom_range(2047), $urandom_range(2047));
		end
		total_cmds = pending_cmds.size();

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		wait (accepted_cmds == total_cmds);
		wait (slots_due.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (slots_due.size() != 0) begin
			$error("%0d results never arrived", slots_due.size());
			failures++;
		end
		if (failures == 0)
			$display("PASS glyph_atlas_shelf_allocator");
		else
			$display("FAIL glyph_atlas_shelf_allocator");
		$finish;
	end

endmodule

[filelist.f]
rtl/gasa_pkg.sv
rtl/gasa_sub_unit.sv
rtl/gasa_ram.sv
rtl/glyph_atlas_shelf_allocator.sv
rtl/gasa_checker.sv
tb/sv/testbench.sv
